FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros used by eif_neuron_update, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property that must hold at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/eif_pkg.sv
// ---------------------------------------------------------------------------
// eif_pkg
// Shared constants, types and the exponential table function of the
// exponential integrate-and-fire neuron update block.
// ---------------------------------------------------------------------------
package eif_pkg;

  // register indexes on the configuration port
  localparam logic [7:0] CFG_LEAK_COEFF    = 8'd0;
  localparam logic [7:0] CFG_DRIVE_TERM    = 8'd1;
  localparam logic [7:0] CFG_EXP_GAIN      = 8'd2;
  localparam logic [7:0] CFG_COMMON_GAIN   = 8'd3;
  localparam logic [7:0] CFG_PRIVATE_GAIN  = 8'd4;
  localparam logic [7:0] CFG_SOFT_THRESH   = 8'd5;
  localparam logic [7:0] CFG_THRESHOLD     = 8'd6;
  localparam logic [7:0] CFG_RESET_VOLTAGE = 8'd7;

  // exponential argument limit (8.0 in Q16.16) and log constants in Q16
  localparam longint ARG_LIMIT = 524288;
  localparam longint LOG2E_Q16 = 94548;
  localparam longint LN2_Q16   = 45426;

  // per-neuron state word
  typedef struct packed {
    logic        has_spiked;
    logic [31:0] last_tick;
    logic [31:0] voltage;
  } eif_state_t;

  // exp(x) for x in Q16.16, as 2^n * 2^f with a fifth order series
  function automatic logic [31:0] exp_fixed(input longint x);
    longint            y;
    longint            n;
    longint unsigned   f;
    longint unsigned   t;
    longint unsigned   tm;
    longint unsigned   sm;
    y  = (x * LOG2E_Q16) >>> 16;
    n  = y >>> 16;
    f  = longint'(unsigned'(y - (n <<< 16)));
    t  = (f * longint'(unsigned'(LN2_Q16))) >> 2;
    tm = 64'd1 << 30;
    sm = tm;
    tm = (tm * t) >> 30;
    sm = sm + tm;
    tm = ((tm * t) >> 30) / 2;
    sm = sm + tm;
    tm = ((tm * t) >> 30) / 3;
    sm = sm + tm;
    tm = ((tm * t) >> 30) / 4;
    sm = sm + tm;
    tm = ((tm * t) >> 30) / 5;
    sm = sm + tm;
    return 32'(sm >> (14 - n));
  endfunction

endpackage

FILE: src/eif_in_if.sv
// ---------------------------------------------------------------------------
// eif_in_if
// Input channel: one Euler step request per beat.
// ---------------------------------------------------------------------------
interface eif_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         neuron_index;
  logic [31:0]        tick_index;
  logic signed [15:0] common_noise;
  logic signed [15:0] private_noise;

  modport source (output valid, neuron_index, tick_index, common_noise, private_noise,
                  input ready);
  modport sink   (input valid, neuron_index, tick_index, common_noise, private_noise,
                  output ready);
endinterface

FILE: src/eif_out_if.sv
// ---------------------------------------------------------------------------
// eif_out_if
// Result channel: one neuron update result per beat.
// ---------------------------------------------------------------------------
interface eif_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_neuron;
  logic               spike_flag;
  logic [31:0]        bin_index;
  logic signed [31:0] new_voltage;
  logic               held_refractory;

  modport source (output valid, out_neuron, spike_flag, bin_index, new_voltage,
                  held_refractory, input ready);
  modport sink   (input valid, out_neuron, spike_flag, bin_index, new_voltage,
                  held_refractory, output ready);
endinterface

FILE: src/eif_cfg_if.sv
// ---------------------------------------------------------------------------
// eif_cfg_if
// Configuration write channel: register index and write data per beat.
// ---------------------------------------------------------------------------
interface eif_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: src/eif_ram.sv
// ---------------------------------------------------------------------------
// eif_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module eif_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/eif_neuron_update.sv
// An accepted input beat passes stages s1 to s5 and the output register to its result beat.
// Throughput: one item per cycle; an item is held at the input while an earlier
// item for the same neuron is still in the 5-stage read-modify-write pipeline.
// The output register stalls the whole pipeline when the result is not taken.
// Reset (rst_n low, synchronous) clears valid bits and per-neuron written flags and
// restores configuration defaults; unwritten neurons read as voltage 0, never spiked, no clear pass.
// ---------------------------------------------------------------------------
// eif_neuron_update
// Exponential integrate-and-fire neuron array, one Euler step per input beat,
// state in a RAM, five register stages from state read to result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eif_neuron_update #(
  parameter int NEURONS        = 256,
  parameter int REFRACT_TICKS  = 20,
  parameter int BIN_TICKS      = 64,
  parameter int INV_SLOPE      = 256,
  parameter int EXP_TABLE_SIZE = 256
) (
  input logic       clk,
  input logic       rst_n,
  eif_cfg_if.sink   cfg_bus,
  eif_in_if.sink    in_bus,
  eif_out_if.source out_bus
);

  import eif_pkg::*;

  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int IW = $clog2(EXP_TABLE_SIZE);
  localparam int SW = $bits(eif_state_t);
  localparam logic [32:0] BIN_RECIP = 33'((64'd1 << 32) / BIN_TICKS);
  localparam logic [16:0] BIN_W     = 17'(BIN_TICKS);

  // configuration registers
  logic [15:0]        leak_coeff_r;
  logic signed [31:0] drive_term_r;
  logic [15:0]        exp_gain_r;
  logic [15:0]        common_gain_r;
  logic [15:0]        private_gain_r;
  logic signed [31:0] soft_thresh_r;
  logic signed [31:0] threshold_r;
  logic signed [31:0] reset_voltage_r;

  assign cfg_bus.ready = 1'b1;

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_coeff_r    <= 16'd655;
      drive_term_r    <= '0;
      exp_gain_r      <= 16'd655;
      common_gain_r   <= '0;
      private_gain_r  <= '0;
      soft_thresh_r   <= '0;
      threshold_r     <= 32'sd1310720;
      reset_voltage_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.addr)
        CFG_LEAK_COEFF:    leak_coeff_r    <= cfg_bus.data[15:0];
        CFG_DRIVE_TERM:    drive_term_r    <= cfg_bus.data;
        CFG_EXP_GAIN:      exp_gain_r      <= cfg_bus.data[15:0];
        CFG_COMMON_GAIN:   common_gain_r   <= cfg_bus.data[15:0];
        CFG_PRIVATE_GAIN:  private_gain_r  <= cfg_bus.data[15:0];
        CFG_SOFT_THRESH:   soft_thresh_r   <= cfg_bus.data;
        CFG_THRESHOLD:     threshold_r     <= cfg_bus.data;
        CFG_RESET_VOLTAGE: reset_voltage_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // exponential table, built at elaboration
  logic [31:0] exp_tab [EXP_TABLE_SIZE];
  for (genvar g = 0; g < EXP_TABLE_SIZE; g++) begin : g_tab
    localparam longint XG = ((longint'(g) << 20) / EXP_TABLE_SIZE) - ARG_LIMIT;
    assign exp_tab[g] = exp_fixed(XG);
  end

  // pipeline registers
  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [7:0]         s1_nrn_r, s2_nrn_r, s3_nrn_r, s4_nrn_r, s5_nrn_r;
  logic               s1_inr_r, s2_inr_r, s3_inr_r, s4_inr_r, s5_inr_r;
  logic [31:0]        s1_tick_r, s2_tick_r, s3_tick_r, s4_tick_r, s5_tick_r;
  logic signed [15:0] s1_cn_r, s1_pn_r;
  logic               s1_wr_r;
  logic signed [31:0] s2_volt_r, s3_volt_r, s4_volt_r, s5_volt_r;
  logic               s2_has_r, s3_has_r, s4_has_r, s5_has_r;
  logic [31:0]        s2_last_r, s3_last_r, s4_last_r, s5_last_r;
  logic               s2_held_r, s3_held_r, s4_held_r, s5_held_r;
  logic signed [32:0] s2_diff_r;
  logic signed [48:0] s2_leak_r;
  logic signed [32:0] s2_cnp_r, s2_pnp_r;
  logic [31:0]        s2_q0_r, s3_q0_r;
  logic [19:0]        s3_arg_r;
  logic signed [35:0] s3_part_r, s4_part_r, s5_part_r;
  logic [32:0]        s3_rem_r;
  logic [IW-1:0]      s4_idx_r;
  logic [31:0]        s4_bin_r, s5_bin_r;
  logic [47:0]        s5_ep_r;

  // output register
  logic               out_v_r;
  logic [7:0]         out_nrn_r;
  logic               out_spike_r;
  logic [31:0]        out_bin_r;
  logic signed [31:0] out_volt_r;
  logic               out_held_r;

  // per-neuron written flags
  logic [NEURONS-1:0] wr_vld_r;

  logic adv;
  logic hazard;
  logic in_acc;
  logic in_range;
  logic [AW-1:0] rd_addr;
  eif_state_t    rd_state;
  eif_state_t    wr_state;
  logic          ram_we;

  assign adv      = !out_v_r || out_bus.ready;
  assign in_range = int'(in_bus.neuron_index) < NEURONS;
  assign rd_addr  = AW'(in_bus.neuron_index);

  // same-neuron items in flight block a new read
  assign hazard = (s1_v_r && s1_nrn_r == in_bus.neuron_index) ||
                  (s2_v_r && s2_nrn_r == in_bus.neuron_index) ||
                  (s3_v_r && s3_nrn_r == in_bus.neuron_index) ||
                  (s4_v_r && s4_nrn_r == in_bus.neuron_index) ||
                  (s5_v_r && s5_nrn_r == in_bus.neuron_index);

  assign in_bus.ready = adv && !hazard;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // state memory
  eif_ram #(.WIDTH(SW), .DEPTH(NEURONS)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(s5_nrn_r)),
    .wdata (wr_state),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (rd_state)
  );

  // stage 1 logic: unwritten neurons read as reset state
  eif_state_t         s1_state;
  logic               s1_held;
  logic [64:0]        s1_qprod;
  assign s1_state = s1_wr_r ? rd_state : '0;
  assign s1_held  = s1_state.has_spiked &&
                    ((s1_tick_r - s1_state.last_tick) <= 32'(REFRACT_TICKS));
  assign s1_qprod = 65'(s1_tick_r) * 65'(BIN_RECIP);

  // stage 2 logic: exponential argument, partial sum, remainder
  logic signed [49:0] s2_argp;
  logic signed [49:0] s2_args;
  logic signed [49:0] s2_argc;
  logic [49:0]        s2_qb;
  assign s2_argp = 50'(s2_diff_r) * 50'($signed({1'b0, 16'(INV_SLOPE)}));
  assign s2_args = s2_argp >>> 8;
  assign s2_qb   = 50'(s2_q0_r) * 50'(BIN_W);
  always_comb begin
    if (s2_args < -50'sd524288) begin
      s2_argc = -50'sd524288;
    end else if (s2_args > 50'sd524287) begin
      s2_argc = 50'sd524287;
    end else begin
      s2_argc = s2_args;
    end
  end

  // stage 3 logic: table index and bin correction
  logic [32:0] s3_iprod;
  assign s3_iprod = 33'(s3_arg_r) * 33'(EXP_TABLE_SIZE);

  // stage 5 logic: final sum, saturation, threshold
  logic signed [35:0] s5_sum;
  logic signed [31:0] s5_sat;
  logic               s5_spike;
  assign s5_sum = s5_part_r + $signed({4'd0, s5_ep_r[47:16]});
  always_comb begin
    if (s5_sum > 36'sd2147483647) begin
      s5_sat = 32'sh7fffffff;
    end else if (s5_sum < -36'sd2147483648) begin
      s5_sat = 32'sh80000000;
    end else begin
      s5_sat = 32'(s5_sum);
    end
  end
  assign s5_spike = !s5_held_r && (s5_sat > threshold_r);

  // state write back
  assign ram_we = adv && s5_v_r && s5_inr_r && !s5_held_r;
  always_comb begin
    if (s5_spike) begin
      wr_state = '{has_spiked: 1'b1, last_tick: s5_tick_r, voltage: reset_voltage_r};
    end else begin
      wr_state = '{has_spiked: s5_has_r, last_tick: s5_last_r, voltage: s5_sat};
    end
  end

  // valid bits and written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      s5_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      wr_vld_r <= '0;
    end else begin
      if (adv) begin
        s1_v_r  <= in_acc;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= s2_v_r;
        s4_v_r  <= s3_v_r;
        s5_v_r  <= s4_v_r;
        out_v_r <= s5_v_r;
      end
      if (ram_we) begin
        wr_vld_r[AW'(s5_nrn_r)] <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: input capture
      s1_nrn_r  <= in_bus.neuron_index;
      s1_inr_r  <= in_range;
      s1_tick_r <= in_bus.tick_index;
      s1_cn_r   <= in_bus.common_noise;
      s1_pn_r   <= in_bus.private_noise;
      s1_wr_r   <= in_range && wr_vld_r[rd_addr];
      // stage 2: products from stored voltage
      s2_nrn_r  <= s1_nrn_r;
      s2_inr_r  <= s1_inr_r;
      s2_tick_r <= s1_tick_r;
      s2_volt_r <= $signed(s1_state.voltage);
      s2_has_r  <= s1_state.has_spiked;
      s2_last_r <= s1_state.last_tick;
      s2_held_r <= s1_held;
      s2_diff_r <= 33'($signed(s1_state.voltage)) - 33'(soft_thresh_r);
      s2_leak_r <= 49'($signed({1'b0, leak_coeff_r})) * 49'($signed(s1_state.voltage));
      s2_cnp_r  <= 33'($signed({1'b0, common_gain_r})) * 33'(s1_cn_r);
      s2_pnp_r  <= 33'($signed({1'b0, private_gain_r})) * 33'(s1_pn_r);
      s2_q0_r   <= s1_qprod[63:32];
      // stage 3: clamped argument and partial sum
      s3_nrn_r  <= s2_nrn_r;
      s3_inr_r  <= s2_inr_r;
      s3_tick_r <= s2_tick_r;
      s3_volt_r <= s2_volt_r;
      s3_has_r  <= s2_has_r;
      s3_last_r <= s2_last_r;
      s3_held_r <= s2_held_r;
      s3_arg_r  <= 20'(s2_argc + 50'sd524288);
      s3_part_r <= 36'(s2_volt_r) - 36'(s2_leak_r >>> 16) + 36'(drive_term_r)
                   + 36'(s2_cnp_r >>> 8) + 36'(s2_pnp_r >>> 8);
      s3_rem_r  <= 33'(s2_tick_r) - 33'(s2_qb);
      s3_q0_r   <= s2_q0_r;
      // stage 4: table index and time bin
      s4_nrn_r  <= s3_nrn_r;
      s4_inr_r  <= s3_inr_r;
      s4_tick_r <= s3_tick_r;
      s4_volt_r <= s3_volt_r;
      s4_has_r  <= s3_has_r;
      s4_last_r <= s3_last_r;
      s4_held_r <= s3_held_r;
      s4_part_r <= s3_part_r;
      s4_idx_r  <= s3_iprod[20 +: IW];
      s4_bin_r  <= (s3_rem_r >= 33'(BIN_W)) ? s3_q0_r + 32'd1 : s3_q0_r;
      // stage 5: exponential term
      s5_nrn_r  <= s4_nrn_r;
      s5_inr_r  <= s4_inr_r;
      s5_tick_r <= s4_tick_r;
      s5_volt_r <= s4_volt_r;
      s5_has_r  <= s4_has_r;
      s5_last_r <= s4_last_r;
      s5_held_r <= s4_held_r;
      s5_part_r <= s4_part_r;
      s5_bin_r  <= s4_bin_r;
      s5_ep_r   <= 48'(exp_gain_r) * 48'(exp_tab[s4_idx_r]);
      // result register
      out_nrn_r <= s5_nrn_r;
      if (!s5_inr_r) begin
        out_spike_r <= 1'b0;
        out_bin_r   <= '0;
        out_volt_r  <= '0;
        out_held_r  <= 1'b0;
      end else if (s5_held_r) begin
        out_spike_r <= 1'b0;
        out_bin_r   <= '0;
        out_volt_r  <= s5_volt_r;
        out_held_r  <= 1'b1;
      end else begin
        out_spike_r <= s5_spike;
        out_bin_r   <= s5_spike ? s5_bin_r : 32'd0;
        out_volt_r  <= s5_spike ? reset_voltage_r : s5_sat;
        out_held_r  <= 1'b0;
      end
    end
  end

  // result beat
  assign out_bus.valid           = out_v_r;
  assign out_bus.out_neuron      = out_nrn_r;
  assign out_bus.spike_flag      = out_spike_r;
  assign out_bus.bin_index       = out_bin_r;
  assign out_bus.new_voltage     = out_volt_r;
  assign out_bus.held_refractory = out_held_r;

  // checks
  `ASSERT_CLK(a_no_rmw_overlap,
    ram_we |-> !(in_acc && in_bus.neuron_index == s5_nrn_r),
    "state write collides with a read of the same neuron")
  `ASSERT_CLK(a_held_no_spike,
    out_v_r && out_held_r |-> !out_spike_r && out_bin_r == 32'd0,
    "held neuron reported a spike")
  `ASSERT_CLK(a_bin_only_on_spike,
    out_v_r && !out_spike_r |-> out_bin_r == 32'd0,
    "time bin set without a spike")

endmodule
